### hw/rtl/bdsl_pkg.sv
`default_nettype none

package bdsl_pkg;

    localparam int SPEED_W    = 13;
    localparam int STEP_W     = 10;
    localparam int HELD_W     = 14;
    localparam int CMD_W      = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam int CMD_MAX = 2047;
    localparam int CMD_MIN = -2048;

    typedef logic signed [HELD_W-1:0] t_speed;
    typedef logic signed [CMD_W-1:0]  t_cmd;
    typedef logic [SPEED_W-1:0]       t_mag;
    typedef logic [STEP_W-1:0]        t_step;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TOP_AXIAL  = 3'd0,
        CFG_TOP_TURN   = 3'd1,
        CFG_TOP_SWEEP  = 3'd2,
        CFG_AXIAL_STEP = 3'd3,
        CFG_TURN_STEP  = 3'd4,
        CFG_SWEEP_STEP = 3'd5
    } t_cfg_idx;

    localparam t_mag  RST_TOP_AXIAL  = 13'd920;
    localparam t_mag  RST_TOP_TURN   = 13'd240;
    localparam t_mag  RST_TOP_SWEEP  = 13'd80;
    localparam t_step RST_AXIAL_STEP = 10'd60;
    localparam t_step RST_TURN_STEP  = 10'd9;
    localparam t_step RST_SWEEP_STEP = 10'd6;

endpackage

`default_nettype wire

### hw/rtl/bdsl_btn_if.sv
`default_nettype none

interface bdsl_btn_if;
    logic valid;
    logic ready;
    logic forward_pressed;
    logic reverse_pressed;
    logic left_pressed;
    logic right_pressed;

    modport source (
        output valid, forward_pressed, reverse_pressed, left_pressed, right_pressed,
        input  ready
    );

    modport sink (
        input  valid, forward_pressed, reverse_pressed, left_pressed, right_pressed,
        output ready
    );
endinterface

`default_nettype wire

### hw/rtl/bdsl_cmd_if.sv
`default_nettype none

interface bdsl_cmd_if;
    import bdsl_pkg::*;

    logic valid;
    logic ready;
    t_cmd axial_command;
    t_cmd yaw_command;

    modport source (
        output valid, axial_command, yaw_command,
        input  ready
    );

    modport sink (
        input  valid, axial_command, yaw_command,
        output ready
    );
endinterface

`default_nettype wire

### hw/rtl/button_drive_slew_limiter.sv
// Button-driven slew limiter for a two-axis drive.
//
// i_btn carries one control tick per transfer: forward, reverse, left and
// right buttons, active high. o_cmd returns one transfer per tick with the
// ramped axial and yaw commands in whole units (held speed shifted right
// by FRAC_BITS, saturated to 12 bits signed).
//
// A tick taken into the button register moves into the command register,
// and so onto o_cmd, when o_cmd is free. Throughput: one tick per cycle while
// o_cmd does not stall, limited by the single update of the two held speeds
// between the button register and the command register.
//
// When o_cmd stalls, the finished command waits in its register and one
// more tick is still taken into the button register; i_btn.ready then
// drops until o_cmd moves again.
//
// Reset (i_rst_n low, synchronous) clears both held speeds, empties the
// pipeline and restores the default limits. The user writes registers
// through i_cfg_we/i_cfg_idx/i_cfg_data only while no tick is in flight;
// the block itself does not enforce this. Unknown indexes are ignored.
`default_nettype none

module button_drive_slew_limiter #(
    parameter int FRAC_BITS = 2
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    bdsl_btn_if.sink                            i_btn,
    bdsl_cmd_if.source                          o_cmd,
    input  wire                                 i_cfg_we,
    input  wire [bdsl_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire [bdsl_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import bdsl_pkg::*;

    t_mag   r_top_axial;
    t_mag   r_top_turn;
    t_mag   r_top_sweep;
    t_step  r_axial_step;
    t_step  r_turn_step;
    t_step  r_sweep_step;

    logic   r_s1_valid;
    logic   r_fwd;
    logic   r_rev;
    logic   r_lft;
    logic   r_rgt;

    t_speed r_axial_now;
    t_speed r_yaw_now;

    logic   r_out_valid;
    t_cmd   r_axial_cmd;
    t_cmd   r_yaw_cmd;

    logic   w_s1_adv;
    logic   w_in_ready;
    logic   w_axial_nz;
    t_speed w_axial_mag;
    t_speed w_yaw_mag;
    t_speed w_axial_tgt;
    t_speed w_yaw_tgt;
    t_step  w_yaw_step;
    t_speed n_axial_now;
    t_speed n_yaw_now;
    t_cmd   n_axial_cmd;
    t_cmd   n_yaw_cmd;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top_axial  <= RST_TOP_AXIAL;
            r_top_turn   <= RST_TOP_TURN;
            r_top_sweep  <= RST_TOP_SWEEP;
            r_axial_step <= RST_AXIAL_STEP;
            r_turn_step  <= RST_TURN_STEP;
            r_sweep_step <= RST_SWEEP_STEP;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TOP_AXIAL:  r_top_axial  <= i_cfg_data[SPEED_W-1:0];
                CFG_TOP_TURN:   r_top_turn   <= i_cfg_data[SPEED_W-1:0];
                CFG_TOP_SWEEP:  r_top_sweep  <= i_cfg_data[SPEED_W-1:0];
                CFG_AXIAL_STEP: r_axial_step <= i_cfg_data[STEP_W-1:0];
                CFG_TURN_STEP:  r_turn_step  <= i_cfg_data[STEP_W-1:0];
                CFG_SWEEP_STEP: r_sweep_step <= i_cfg_data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // handshake
    assign w_s1_adv   = r_s1_valid && (!r_out_valid || o_cmd.ready);
    assign w_in_ready = !r_s1_valid || w_s1_adv;
    assign i_btn.ready = w_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_ready) begin
            r_s1_valid <= i_btn.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_ready && i_btn.valid) begin
            r_fwd <= i_btn.forward_pressed;
            r_rev <= i_btn.reverse_pressed;
            r_lft <= i_btn.left_pressed;
            r_rgt <= i_btn.right_pressed;
        end
    end

    // targets; forward beats reverse, right beats left
    assign w_axial_mag = $signed({1'b0, r_top_axial});
    assign w_axial_nz  = (r_fwd || r_rev) && (r_top_axial != '0);
    assign w_yaw_mag   = w_axial_nz ? $signed({1'b0, r_top_sweep}) : $signed({1'b0, r_top_turn});
    assign w_yaw_step  = ((r_rgt || r_lft) && w_axial_nz) ? r_sweep_step : r_turn_step;

    always_comb begin
        if (r_fwd) begin
            w_axial_tgt = w_axial_mag;
        end else if (r_rev) begin
            w_axial_tgt = -w_axial_mag;
        end else begin
            w_axial_tgt = '0;
        end

        if (r_rgt) begin
            w_yaw_tgt = w_yaw_mag;
        end else if (r_lft) begin
            w_yaw_tgt = -w_yaw_mag;
        end else begin
            w_yaw_tgt = '0;
        end
    end

    bdsl_ramp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_axial_ramp (
        .i_target     (w_axial_tgt),
        .i_now        (r_axial_now),
        .i_step_limit (r_axial_step),
        .o_next       (n_axial_now),
        .o_cmd        (n_axial_cmd)
    );

    bdsl_ramp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_yaw_ramp (
        .i_target     (w_yaw_tgt),
        .i_now        (r_yaw_now),
        .i_step_limit (w_yaw_step),
        .o_next       (n_yaw_now),
        .o_cmd        (n_yaw_cmd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axial_now <= '0;
            r_yaw_now   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_s1_adv) begin
                r_axial_now <= n_axial_now;
                r_yaw_now   <= n_yaw_now;
                r_out_valid <= 1'b1;
            end else if (o_cmd.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_axial_cmd <= n_axial_cmd;
            r_yaw_cmd   <= n_yaw_cmd;
        end
    end

    assign o_cmd.valid         = r_out_valid;
    assign o_cmd.axial_command = r_axial_cmd;
    assign o_cmd.yaw_command   = r_yaw_cmd;

`ifndef SYNTHESIS
    a_axial_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_axial_now >= -8191 && r_axial_now <= 8191)
        else $error("axial held speed out of range");

    a_yaw_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_yaw_now >= -8191 && r_yaw_now <= 8191)
        else $error("yaw held speed out of range");

    a_adv_gives_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s1_adv |=> r_out_valid)
        else $error("tick advanced without a command");

    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_s1_adv |=> $stable(r_axial_now) && $stable(r_yaw_now))
        else $error("held speed changed without a tick");

    a_yaw_decay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s1_adv && !r_lft && !r_rgt && r_yaw_now >= 0
        |=> r_yaw_now >= 0 && r_yaw_now <= $past(r_yaw_now))
        else $error("yaw did not ramp toward zero");
`endif

endmodule

`default_nettype wire

### hw/rtl/bdsl_ramp.sv
`default_nettype none

module bdsl_ramp #(
    parameter int FRAC_BITS = 2
) (
    input  bdsl_pkg::t_speed i_target,
    input  bdsl_pkg::t_speed i_now,
    input  bdsl_pkg::t_step  i_step_limit,
    output bdsl_pkg::t_speed o_next,
    output bdsl_pkg::t_cmd   o_cmd
);
    import bdsl_pkg::*;

    logic [STEP_W:0]        w_step_raw;
    logic [STEP_W:0]        w_step;
    logic signed [HELD_W:0] w_step_s;
    logic signed [HELD_W:0] w_target_x;
    logic signed [HELD_W:0] w_now_x;
    logic signed [HELD_W:0] w_diff;
    logic signed [HELD_W:0] w_up;
    logic signed [HELD_W:0] w_down;
    t_speed                 w_next;
    t_speed                 w_shift;

    // step doubles toward zero, and never drops below one
    assign w_step_raw = (i_target == '0) ? {i_step_limit, 1'b0} : {1'b0, i_step_limit};
    assign w_step     = (w_step_raw == '0) ? (STEP_W+1)'(1) : w_step_raw;
    assign w_step_s   = $signed({{(HELD_W-STEP_W){1'b0}}, w_step});

    assign w_target_x = $signed({i_target[HELD_W-1], i_target});
    assign w_now_x    = $signed({i_now[HELD_W-1], i_now});
    assign w_diff     = w_target_x - w_now_x;
    assign w_up       = w_now_x + w_step_s;
    assign w_down     = w_now_x - w_step_s;

    always_comb begin
        if (w_diff > w_step_s) begin
            w_next = w_up[HELD_W-1:0];
        end else if (w_diff < -w_step_s) begin
            w_next = w_down[HELD_W-1:0];
        end else begin
            w_next = i_target;
        end
    end

    assign o_next  = w_next;
    assign w_shift = w_next >>> FRAC_BITS;

    always_comb begin
        if (w_shift > CMD_MAX) begin
            o_cmd = t_cmd'(CMD_MAX);
        end else if (w_shift < CMD_MIN) begin
            o_cmd = t_cmd'(CMD_MIN);
        end else begin
            o_cmd = w_shift[CMD_W-1:0];
        end
    end

endmodule

`default_nettype wire

### tb/sv/bdsl_slew_check.sv
module bdsl_slew_check
    import bdsl_pkg::*;
#(
    parameter int FRAC_BITS = 2
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    bdsl_btn_if                  btn,
    bdsl_cmd_if                  cmd,
    input  wire                  i_cfg_we,
    input  wire [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire [CFG_DATA_W-1:0] i_cfg_data,
    output int                   o_errors,
    output int                   o_pending
);

    typedef struct packed {
        t_cmd axial;
        t_cmd yaw;
    } t_cmd_pair;

    t_mag      top_axial;
    t_mag      top_turn;
    t_mag      top_sweep;
    t_step     axial_step;
    t_step     turn_step;
    t_step     sweep_step;
    t_speed    axial_now;
    t_speed    yaw_now;
    t_cmd_pair cmd_queue[$];
    int        mismatches = 0;

    // one tick of the ramp: step doubles toward zero, never below 1
    function automatic int slew(input int target, input int held, input int step);
        int lim;
        lim = (target == 0) ? 2 * step : step;
        if (lim == 0)
            lim = 1;
        if (target - held > lim)
            return held + lim;
        if (target - held < -lim)
            return held - lim;
        return target;
    endfunction

    function automatic t_cmd to_cmd(input int held);
        int whole;
        whole = held >>> FRAC_BITS;
        if (whole > CMD_MAX)
            whole = CMD_MAX;
        if (whole < CMD_MIN)
            whole = CMD_MIN;
        return t_cmd'(whole);
    endfunction

    always @(posedge i_clk) begin : track
        t_cmd_pair want;
        t_cmd_pair got;
        int        ax_tgt;
        int        yaw_tgt;
        int        yaw_mag;
        int        yaw_lim;

        if (!i_rst_n) begin
            top_axial  = RST_TOP_AXIAL;
            top_turn   = RST_TOP_TURN;
            top_sweep  = RST_TOP_SWEEP;
            axial_step = RST_AXIAL_STEP;
            turn_step  = RST_TURN_STEP;
            sweep_step = RST_SWEEP_STEP;
            axial_now  = '0;
            yaw_now    = '0;
            cmd_queue.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_TOP_AXIAL:  top_axial  = i_cfg_data;
                    CFG_TOP_TURN:   top_turn   = i_cfg_data;
                    CFG_TOP_SWEEP:  top_sweep  = i_cfg_data;
                    CFG_AXIAL_STEP: axial_step = i_cfg_data[STEP_W-1:0];
                    CFG_TURN_STEP:  turn_step  = i_cfg_data[STEP_W-1:0];
                    CFG_SWEEP_STEP: sweep_step = i_cfg_data[STEP_W-1:0];
                    default: ;
                endcase
            end

            // result side first: a tick taken this edge cannot be out yet
            if (cmd.valid && cmd.ready) begin
                got.axial = cmd.axial_command;
                got.yaw   = cmd.yaw_command;
                if (cmd_queue.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%t: command transfer with none pending: axial %0d yaw %0d",
                                 $realtime, got.axial, got.yaw);
                end else begin
                    want = cmd_queue.pop_front();
                    if (got.axial !== want.axial || got.yaw !== want.yaw) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%t: command mismatch: axial exp %0d got %0d, yaw exp %0d got %0d",
                                     $realtime, want.axial, got.axial, want.yaw, got.yaw);
                    end
                end
            end

            if (btn.valid && btn.ready) begin
                ax_tgt = 0;
                if (btn.forward_pressed)
                    ax_tgt = int'(top_axial);
                else if (btn.reverse_pressed)
                    ax_tgt = -int'(top_axial);

                yaw_mag = (ax_tgt == 0) ? int'(top_turn) : int'(top_sweep);
                yaw_lim = int'(turn_step);
                yaw_tgt = 0;
                if (btn.right_pressed || btn.left_pressed) begin
                    if (ax_tgt != 0)
                        yaw_lim = int'(sweep_step);
                    yaw_tgt = btn.right_pressed ? yaw_mag : -yaw_mag;
                end

                axial_now = t_speed'(slew(ax_tgt, int'(axial_now), int'(axial_step)));
                yaw_now   = t_speed'(slew(yaw_tgt, int'(yaw_now), yaw_lim));

                want.axial = to_cmd(int'(axial_now));
                want.yaw   = to_cmd(int'(yaw_now));
                cmd_queue.push_back(want);
            end
        end

        o_errors  <= mismatches;
        o_pending <= cmd_queue.size();
    end

endmodule

### tb/sv/button_drive_slew_limiter_tb.sv
module button_drive_slew_limiter_tb;
    import bdsl_pkg::*;

    localparam int FRAC_BITS   = 2;
    localparam int QUIET_LIMIT = 1000;
    localparam int PAD_W       = CFG_DATA_W - STEP_W;

    // indexes past the register list; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic fwd;
        logic rev;
        logic lft;
        logic rig;
    } t_buttons;

    localparam t_buttons NONE = 4'b0000;
    localparam t_buttons FWD  = 4'b1000;
    localparam t_buttons REV  = 4'b0100;
    localparam t_buttons LFT  = 4'b0010;
    localparam t_buttons RIG  = 4'b0001;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    bit                    idle_en = 1'b0;
    bit                    stall_en = 1'b0;
    int                    errors;
    int                    pending;
    int                    quiet = 0;

    bdsl_btn_if btn ();
    bdsl_cmd_if cmd ();

    button_drive_slew_limiter #(
        .FRAC_BITS (FRAC_BITS)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_btn      (btn),
        .o_cmd      (cmd),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    bdsl_slew_check #(
        .FRAC_BITS (FRAC_BITS)
    ) u_slew_check (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .btn        (btn),
        .cmd        (cmd),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // command sink: drops ready in random bursts while stall_en is set
    initial begin : sink_ready
        int hold;
        hold = 0;
        cmd.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold > 0) begin
                hold--;
                cmd.ready <= 1'b0;
            end else if (stall_en && $urandom_range(0, 7) == 0) begin
                hold = $urandom_range(1, 14) - 1;
                cmd.ready <= 1'b0;
            end else begin
                cmd.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (btn.valid && btn.ready) || (cmd.valid && cmd.ready)) begin
            quiet <= 0;
        end else if (quiet == QUIET_LIMIT) begin
            $display("button_drive_slew_limiter_tb: done, errors");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    task automatic send_tick(input t_buttons b);
        btn.valid           <= 1'b1;
        btn.forward_pressed <= b.fwd;
        btn.reverse_pressed <= b.rev;
        btn.left_pressed    <= b.lft;
        btn.right_pressed   <= b.rig;
        @(posedge clk);
        while (!btn.ready)
            @(posedge clk);
        if (idle_en && $urandom_range(0, 5) == 0) begin
            btn.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
    endtask

    task automatic send_run(input t_buttons b, input int len);
        repeat (len) send_tick(b);
    endtask

    // mostly held button patterns so the ramps reach their targets
    task automatic run_ticks(input int n, input bit allow_idle);
        int sent;
        int len;
        sent = 0;
        while (sent < n) begin
            idle_en  = allow_idle && ($urandom_range(0, 3) != 0);
            stall_en = allow_idle && ($urandom_range(0, 3) != 0);
            len = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 40);
            send_run(t_buttons'($urandom_range(0, 15)), len);
            sent += len;
        end
    endtask

    task automatic drain();
        btn.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    // step registers get random bits above their width; those are dropped
    task automatic apply_settings(input t_mag top_ax, input t_mag top_turn,
                                  input t_mag top_sweep, input t_step ax_step,
                                  input t_step turn_step, input t_step sweep_step);
        write_reg(CFG_TOP_AXIAL, top_ax);
        write_reg(CFG_TOP_TURN, top_turn);
        write_reg(CFG_TOP_SWEEP, top_sweep);
        write_reg(CFG_AXIAL_STEP, {PAD_W'($urandom), ax_step});
        write_reg(CFG_TURN_STEP, {PAD_W'($urandom), turn_step});
        write_reg(CFG_SWEEP_STEP, {PAD_W'($urandom), sweep_step});
        write_reg(CFG_SPARE_LO, CFG_DATA_W'($urandom));
        write_reg(CFG_SPARE_HI, CFG_DATA_W'($urandom));
        cfg_we <= 1'b0;
    endtask

    task automatic apply_random_settings();
        apply_settings(t_mag'($urandom), t_mag'($urandom), t_mag'($urandom),
                       t_step'($urandom), t_step'($urandom), t_step'($urandom));
    endtask

    initial begin
        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_idx             <= '0;
        cfg_data            <= '0;
        btn.valid           <= 1'b0;
        btn.forward_pressed <= 1'b0;
        btn.reverse_pressed <= 1'b0;
        btn.left_pressed    <= 1'b0;
        btn.right_pressed   <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // reset limits: ramp up, sweep, conflicting buttons, ramp down
        idle_en  = 1'b1;
        stall_en = 1'b1;
        send_run(FWD, 8);
        send_run(FWD | RIG, 3);
        send_run(FWD | REV | LFT | RIG, 3);
        send_run(REV | LFT, 2);
        send_run(NONE, 3);
        send_run(LFT | RIG, 2);
        send_run(REV, 2);
        send_run(LFT, 1);
        run_ticks(150, 1'b1);

        drain();
        apply_settings('1, '1, '1, '1, '1, '1);
        run_ticks(150, 1'b1);

        // zero limits and steps: every target is zero, held speeds creep toward zero by 1
        drain();
        apply_settings('0, '0, '0, '0, '0, '0);
        run_ticks(100, 1'b1);

        // no axial speed: forward/reverse keep the in-place yaw path
        drain();
        apply_settings('0, t_mag'($urandom), t_mag'($urandom),
                       t_step'($urandom), t_step'($urandom_range(0, 40)),
                       t_step'($urandom_range(0, 40)));
        run_ticks(150, 1'b1);

        drain();
        apply_settings('1, t_mag'($urandom), t_mag'($urandom), '0, '0, '0);
        run_ticks(150, 1'b1);

        repeat (3) begin
            drain();
            apply_random_settings();
            run_ticks(150, 1'b1);
        end

        // last part runs with no idling on either side
        idle_en  = 1'b0;
        stall_en = 1'b0;
        drain();
        apply_random_settings();
        run_ticks(200, 1'b0);

        drain();
        repeat (4) @(posedge clk);
        if (errors == 0)
            $display("button_drive_slew_limiter_tb: done, clean");
        else
            $display("button_drive_slew_limiter_tb: done, errors");
        $finish;
    end

endmodule

### sim.f
hw/rtl/bdsl_pkg.sv
hw/rtl/bdsl_btn_if.sv
hw/rtl/bdsl_cmd_if.sv
hw/rtl/bdsl_ramp.sv
hw/rtl/button_drive_slew_limiter.sv
tb/sv/bdsl_slew_check.sv
tb/sv/button_drive_slew_limiter_tb.sv
